FILE: rtl/integer_alu_with_mul_div_unit_defines.svh
// Assertion macros shared by the checker.
`ifndef INTEGER_ALU_WITH_MUL_DIV_UNIT_DEFINES_SVH
`define INTEGER_ALU_WITH_MUL_DIV_UNIT_DEFINES_SVH

`define IAMD_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

`define IAMD_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/iamd_pkg.sv
`timescale 1ns / 1ps
package iamd_pkg;

  typedef enum logic [4:0] {
    OP_ADD    = 5'd0,
    OP_SUB    = 5'd1,
    OP_SLL    = 5'd2,
    OP_SLT    = 5'd3,
    OP_SLTU   = 5'd4,
    OP_XOR    = 5'd5,
    OP_SRL    = 5'd6,
    OP_SRA    = 5'd7,
    OP_OR     = 5'd8,
    OP_AND    = 5'd9,
    OP_MUL    = 5'd10,
    OP_MULH   = 5'd11,
    OP_MULHSU = 5'd12,
    OP_MULHU  = 5'd13,
    OP_DIV    = 5'd14,
    OP_DIVU   = 5'd15,
    OP_REM    = 5'd16,
    OP_REMU   = 5'd17
  } op_t;

  localparam int unsigned XLEN = 32;

  typedef logic [XLEN-1:0] word_t;

  typedef struct packed {
    logic  is_mul;
    logic  is_div;
    logic  mul_hi;
    logic  a_signed;
    logic  b_signed;
    logic  want_rem;
    logic  div_zero;
    logic  div_ovf;
    logic  neg_q;
    logic  neg_r;
    word_t simple;
  } ctl_t;

endpackage

FILE: rtl/iamd_stage.sv
`timescale 1ns / 1ps
module iamd_stage
  import iamd_pkg::*;
#(
  parameter int unsigned W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         up_valid,
  output logic         up_ready,
  input  logic [W-1:0] up_data,
  output logic         dn_valid,
  input  logic         dn_ready,
  output logic [W-1:0] dn_data
);

  logic         valid_r;
  logic [W-1:0] data_r;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= up_data;
    end
  end

endmodule

FILE: rtl/iamd_div_step.sv
`timescale 1ns / 1ps
module iamd_div_step
  import iamd_pkg::*;
#(
  parameter int unsigned BITS = 4
) (
  input  word_t rem_in,
  input  word_t quo_in,
  input  word_t dvs,
  output word_t rem_out,
  output word_t quo_out
);

  logic [XLEN:0] trial [BITS+1];
  word_t         r    [BITS+1];
  word_t         q    [BITS+1];

  always_comb begin
    r[0] = rem_in;
    q[0] = quo_in;
    for (int i = 0; i < BITS; i++) begin
      trial[i]  = {r[i], q[i][XLEN-1]} - {1'b0, dvs};
      if (!trial[i][XLEN]) begin
        r[i+1] = trial[i][XLEN-1:0];
        q[i+1] = {q[i][XLEN-2:0], 1'b1};
      end else begin
        r[i+1] = {r[i][XLEN-2:0], q[i][XLEN-1]};
        q[i+1] = {q[i][XLEN-2:0], 1'b0};
      end
    end
    trial[BITS] = '0;
  end

  assign rem_out = r[BITS];
  assign quo_out = q[BITS];

endmodule

FILE: rtl/integer_alu_with_mul_div_unit.sv
`timescale 1ns / 1ps
// RV32IM integer execute unit, fully pipelined.
// Input channel: in_valid/in_ready with in_mode, in_operand_a, in_operand_b.
// Result channel: out_valid/out_ready with out_result.
// Every request gives exactly one result, in order of arrival.
// The pipe has 11 register stages: one decode stage, one multiplier stage,
// eight divider stages of four quotient bits each, the first of them shared
// with the second multiplier partial product, and a fixing stage that drives
// the output.
// Throughput is one request per cycle while out_ready is high; the chain of divider stages sets
// the depth and every operation travels through all of it.
// Each stage has its own valid bit and a ready that is open when the
// stage is empty or the next one takes its content, so a stalled
// receiver fills the pipe without loss, then in_ready drops.
// Reset clears all valid bits; payload registers are not reset.
module integer_alu_with_mul_div_unit
  import iamd_pkg::*;
#(
  parameter int unsigned DIV_BITS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [4:0]  in_mode,
  input  logic [31:0] in_operand_a,
  input  logic [31:0] in_operand_b,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_result
);

  localparam int unsigned NDIV = XLEN / DIV_BITS;
  localparam int unsigned NST  = NDIV + 3;

  typedef struct packed {
    ctl_t  c;
    word_t a;
    word_t b;
    word_t rem;
    word_t quo;
    logic [2*XLEN-1:0] prod;
  } pipe_t;

  localparam int unsigned PW = $bits(pipe_t);

  logic  v   [NST+1];
  logic  rdy [NST+1];
  pipe_t d   [NST];
  pipe_t q   [NST];

  ctl_t  c0;
  word_t ua, ub;
  logic  na, nb;

  always_comb begin
    na = in_operand_a[XLEN-1];
    nb = in_operand_b[XLEN-1];
    c0 = '0;
    c0.simple = '0;
    case (in_mode)
      OP_ADD:  c0.simple = in_operand_a + in_operand_b;
      OP_SUB:  c0.simple = in_operand_a - in_operand_b;
      OP_SLL:  c0.simple = in_operand_a << in_operand_b[4:0];
      OP_SLT:  c0.simple = {31'd0, $signed(in_operand_a) < $signed(in_operand_b)};
      OP_SLTU: c0.simple = {31'd0, in_operand_a < in_operand_b};
      OP_XOR:  c0.simple = in_operand_a ^ in_operand_b;
      OP_SRL:  c0.simple = in_operand_a >> in_operand_b[4:0];
      OP_SRA:  c0.simple = word_t'($signed(in_operand_a) >>> in_operand_b[4:0]);
      OP_OR:   c0.simple = in_operand_a | in_operand_b;
      OP_AND:  c0.simple = in_operand_a & in_operand_b;
      default: c0.simple = '0;
    endcase
    c0.is_mul   = (in_mode == OP_MUL) || (in_mode == OP_MULH) ||
                  (in_mode == OP_MULHSU) || (in_mode == OP_MULHU);
    c0.mul_hi   = (in_mode == OP_MULH) || (in_mode == OP_MULHSU) ||
                  (in_mode == OP_MULHU);
    c0.a_signed = (in_mode == OP_MULH) || (in_mode == OP_MULHSU);
    c0.b_signed = (in_mode == OP_MULH);
    c0.is_div   = (in_mode == OP_DIV) || (in_mode == OP_DIVU) ||
                  (in_mode == OP_REM) || (in_mode == OP_REMU);
    c0.want_rem = (in_mode == OP_REM) || (in_mode == OP_REMU);
    c0.div_zero = (in_operand_b == '0);
    c0.div_ovf  = ((in_mode == OP_DIV) || (in_mode == OP_REM)) &&
                  (in_operand_a == 32'h8000_0000) && (in_operand_b == '1);
    if ((in_mode == OP_DIV) || (in_mode == OP_REM)) begin
      c0.neg_q = na ^ nb;
      c0.neg_r = na;
      ua = na ? -in_operand_a : in_operand_a;
      ub = nb ? -in_operand_b : in_operand_b;
    end else begin
      ua = in_operand_a;
      ub = in_operand_b;
    end
    d[0].c    = c0;
    d[0].a    = in_operand_a;
    d[0].b    = ub;
    d[0].rem  = '0;
    d[0].quo  = ua;
    d[0].prod = '0;
  end

  assign v[0]     = in_valid;
  assign in_ready = rdy[0];

  for (genvar s = 0; s < NST; s++) begin : g_st
    iamd_stage #(.W(PW)) u_st (
      .clk(clk), .rst_n(rst_n),
      .up_valid(v[s]), .up_ready(rdy[s]), .up_data(d[s]),
      .dn_valid(v[s+1]), .dn_ready(rdy[s+1]), .dn_data(q[s])
    );
  end

  // Stage 1 input: partial product of a by the low half of b.
  always_comb begin
    d[1] = q[0];
    d[1].prod = {16'd0, ({16'd0, q[0].a} * {32'd0, q[0].b[15:0]})};
  end

  for (genvar k = 0; k < NDIV; k++) begin : g_div
    if (k >= 1) begin : g_mid
      iamd_div_step #(.BITS(DIV_BITS)) u_ds (
        .rem_in(q[k+1].rem), .quo_in(q[k+1].quo), .dvs(q[k+1].b),
        .rem_out(d[k+2].rem), .quo_out(d[k+2].quo)
      );
      assign d[k+2].c    = q[k+1].c;
      assign d[k+2].a    = q[k+1].a;
      assign d[k+2].b    = q[k+1].b;
      assign d[k+2].prod = q[k+1].prod;
    end
  end

  // Divider steps run on stage 2..; the first step sits on stage 2 input
  // side together with the second multiplier partial product.
  word_t r2, qq2;
  iamd_div_step #(.BITS(DIV_BITS)) u_ds0 (
    .rem_in(q[1].rem), .quo_in(q[1].quo), .dvs(q[1].b),
    .rem_out(r2), .quo_out(qq2)
  );

  always_comb begin
    d[2] = q[1];
    d[2].prod = q[1].prod + {({16'd0, q[1].a} * {32'd0, q[1].b[31:16]}), 16'd0};
    d[2].rem  = r2;
    d[2].quo  = qq2;
  end

  logic  [2*XLEN-1:0] pf;
  word_t hi, rq, rr, res;
  always_comb begin
    pf = q[NST-2].prod;
    hi = pf[2*XLEN-1:XLEN];
    if (q[NST-2].c.a_signed && q[NST-2].a[XLEN-1]) hi = hi - q[NST-2].b;
    if (q[NST-2].c.b_signed && q[NST-2].b[XLEN-1]) hi = hi - q[NST-2].a;
    rq = q[NST-2].c.neg_q ? -q[NST-2].quo : q[NST-2].quo;
    rr = q[NST-2].c.neg_r ? -q[NST-2].rem : q[NST-2].rem;
    if (q[NST-2].c.div_zero) begin
      rq = '1;
      rr = q[NST-2].a;
    end
    if (q[NST-2].c.div_ovf) begin
      rq = 32'h8000_0000;
      rr = '0;
    end
    if (q[NST-2].c.is_mul) res = q[NST-2].c.mul_hi ? hi : pf[XLEN-1:0];
    else if (q[NST-2].c.is_div) res = q[NST-2].c.want_rem ? rr : rq;
    else res = q[NST-2].c.simple;
    d[NST-1]      = q[NST-2];
    d[NST-1].quo  = res;
  end

  assign out_valid   = v[NST];
  assign rdy[NST]    = out_ready;
  assign out_result  = q[NST-1].quo;

endmodule

FILE: rtl/iamd_checker.sv
`timescale 1ns / 1ps
`include "integer_alu_with_mul_div_unit_defines.svh"
module iamd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_result
);

  logic out_stall;

  assign out_stall = out_valid && !out_ready;

  `IAMD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid, "Result dropped.")
  `IAMD_ASSERT_NEXT(a_out_data, clk, rst_n, out_stall, $stable(out_result), "Result changed.")
  `IAMD_ASSERT_IMPL(a_ready_free, clk, rst_n, !out_valid, in_ready, "Input blocked while empty.")
  `IAMD_ASSERT_IMPL(a_ready_open, clk, rst_n, out_ready, in_ready, "Input blocked while taken.")

endmodule

bind integer_alu_with_mul_div_unit iamd_checker u_iamd_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_result(out_result)
);
